// ----- hw/rtl/rbs_pkg.sv -----
package rbs_pkg;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LOW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HIGH_Z = 3'd5;

    localparam logic signed [VAL_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] NEG_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VAL_W-1:0] origin_x;
        logic signed [VAL_W-1:0] origin_y;
        logic signed [VAL_W-1:0] origin_z;
        logic signed [VAL_W-1:0] dir_x;
        logic signed [VAL_W-1:0] dir_y;
        logic signed [VAL_W-1:0] dir_z;
    } t_ray_in;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] entry_distance;
    } t_ray_out;

    typedef struct packed {
        logic [5:0] neg;
        logic [2:0] zero;
        logic [2:0] in_slab;
    } t_side;

endpackage

// ----- hw/rtl/rbs_div.sv -----
module rbs_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [rbs_pkg::VAL_W+FRAC_BITS-1:0]  i_num,
    input  logic [rbs_pkg::VAL_W-1:0]            i_den,
    output logic [rbs_pkg::VAL_W+FRAC_BITS-1:0]  o_quo
);

    localparam int NW = rbs_pkg::VAL_W + FRAC_BITS;
    localparam int DW = rbs_pkg::VAL_W;

    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] r_den [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_stage
            logic [NW-1:0] nq_in;
            logic [DW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [DW:0]   t;
            logic [DW:0]   diff;
            logic          ge;
            logic [NW-1:0] n_nq;
            logic [DW-1:0] n_rem;

            if (k == 0) begin : g_first
                assign nq_in  = i_num;
                assign rem_in = '0;
                assign den_in = i_den;
            end else begin : g_next
                assign nq_in  = r_nq[k-1];
                assign rem_in = r_rem[k-1];
                assign den_in = r_den[k-1];
            end

            always_comb begin
                t     = {rem_in, nq_in[NW-1]};
                diff  = t - {1'b0, den_in};
                ge    = (t >= {1'b0, den_in});
                n_rem = ge ? diff[DW-1:0] : t[DW-1:0];
                n_nq  = {nq_in[NW-2:0], ge};
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_nq[k]  <= n_nq;
                    r_rem[k] <= n_rem;
                    r_den[k] <= den_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_nq[NW-1];

endmodule

// ----- hw/rtl/ray_box_slab_intersect.sv -----
// Ray versus axis-aligned box by the slab method, signed fixed point with FRAC_BITS
// fraction bits. The box is six registers written through the plain write port; the
// user must write them only while the block is idle; the block does not enforce it.
// One ray transfers per cycle unless the result side stalls. The pipeline holds six
// restoring dividers that resolve one quotient bit per stage, 32 + FRAC_BITS stages
// deep, plus two stages of slab setup and three of saturation, interval merge and
// output. A stall on the result side freezes the whole pipeline. A miss reports hit
// low and the largest positive entry distance.
module ray_box_slab_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  rbs_pkg::t_ray_in                    i_ray,
    output logic                                o_valid,
    input  logic                                i_stall,
    output rbs_pkg::t_ray_out                   o_res,
    input  logic                                i_cfg_we,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rbs_pkg::VAL_W-1:0]           i_cfg_data
);

    localparam int W  = rbs_pkg::VAL_W;
    localparam int NW = W + FRAC_BITS;

    logic signed [W-1:0] r_lo [3];
    logic signed [W-1:0] r_hi [3];

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbs_pkg::CFG_BOX_LOW_X:  r_lo[0] <= i_cfg_data;
                rbs_pkg::CFG_BOX_LOW_Y:  r_lo[1] <= i_cfg_data;
                rbs_pkg::CFG_BOX_LOW_Z:  r_lo[2] <= i_cfg_data;
                rbs_pkg::CFG_BOX_HIGH_X: r_hi[0] <= i_cfg_data;
                rbs_pkg::CFG_BOX_HIGH_Y: r_hi[1] <= i_cfg_data;
                rbs_pkg::CFG_BOX_HIGH_Z: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];
    assign org[0] = i_ray.origin_x;
    assign org[1] = i_ray.origin_y;
    assign org[2] = i_ray.origin_z;
    assign dir[0] = i_ray.dir_x;
    assign dir[1] = i_ray.dir_y;
    assign dir[2] = i_ray.dir_z;

    // stage A: bound differences
    logic                r_va;
    logic signed [W:0]   r_dlo [3];
    logic signed [W:0]   r_dhi [3];
    logic signed [W-1:0] r_dir [3];
    logic [2:0]          r_ins_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_dlo[a]   <= {r_lo[a][W-1], r_lo[a]} - {org[a][W-1], org[a]};
                r_dhi[a]   <= {r_hi[a][W-1], r_hi[a]} - {org[a][W-1], org[a]};
                r_dir[a]   <= dir[a];
                r_ins_a[a] <= (org[a] >= r_lo[a]) && (org[a] <= r_hi[a]);
            end
        end
    end

    // stage B: order bounds, take magnitudes
    logic              r_vb;
    logic [W-1:0]      r_nmag [6];
    logic [W-1:0]      r_dmag [6];
    rbs_pkg::t_side    r_side_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [W:0] nn;
        logic signed [W:0] nf;
        logic [W:0]        mn;
        logic [W:0]        mf;
        logic [W-1:0]      md;
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                nn = r_dir[a][W-1] ? r_dhi[a] : r_dlo[a];
                nf = r_dir[a][W-1] ? r_dlo[a] : r_dhi[a];
                mn = nn[W] ? -nn : nn;
                mf = nf[W] ? -nf : nf;
                md = r_dir[a][W-1] ? -r_dir[a] : r_dir[a];
                r_nmag[2*a]   <= mn[W-1:0];
                r_nmag[2*a+1] <= mf[W-1:0];
                r_dmag[2*a]   <= md;
                r_dmag[2*a+1] <= md;
                r_side_b.neg[2*a]    <= nn[W] ^ r_dir[a][W-1];
                r_side_b.neg[2*a+1]  <= nf[W] ^ r_dir[a][W-1];
                r_side_b.zero[a]     <= (r_dir[a] == '0);
                r_side_b.in_slab[a]  <= r_ins_a[a];
            end
        end
    end

    // divider lanes with matching sideband line
    logic [NW-1:0] quo [6];

    genvar g;
    generate
        for (g = 0; g < 6; g++) begin : g_lane
            rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num ({r_nmag[g], {FRAC_BITS{1'b0}}}),
                .i_den (r_dmag[g]),
                .o_quo (quo[g])
            );
        end
    endgenerate

    logic           r_vd   [NW];
    rbs_pkg::t_side r_side [NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (en) begin
            r_vd[0] <= r_vb;
            for (int k = 1; k < NW; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_side_b;
            for (int k = 1; k < NW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // stage C: sign, saturate, unbounded slabs
    logic                r_vc;
    logic signed [W-1:0] r_t [6];
    logic [2:0]          r_ok_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (en) begin
            r_vc <= r_vd[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NW-1:0] q;
        logic signed [W-1:0] tv;
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                q = quo[l];
                if (r_side[NW-1].neg[l]) begin
                    if ((|q[NW-1:W]) || (q[W-1] && (|q[W-2:0]))) begin
                        tv = rbs_pkg::NEG_MIN;
                    end else begin
                        tv = -q[W-1:0];
                    end
                end else begin
                    tv = (|q[NW-1:W-1]) ? rbs_pkg::POS_MAX : q[W-1:0];
                end
                if (r_side[NW-1].zero[l/2]) begin
                    tv = (l % 2 == 0) ? rbs_pkg::NEG_MIN : rbs_pkg::POS_MAX;
                end
                r_t[l] <= tv;
            end
            for (int a = 0; a < 3; a++) begin
                r_ok_c[a] <= !r_side[NW-1].zero[a] || r_side[NW-1].in_slab[a];
            end
        end
    end

    // stage D: merge x and y
    logic                r_vdd;
    logic                r_ok_d;
    logic signed [W-1:0] r_mn;
    logic signed [W-1:0] r_mf;
    logic signed [W-1:0] r_zn;
    logic signed [W-1:0] r_zf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vdd <= 1'b0;
        end else if (en) begin
            r_vdd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok_d <= r_ok_c[0] && r_ok_c[1] && r_ok_c[2]
                      && !((r_t[0] > r_t[3]) || (r_t[2] > r_t[1]));
            r_mn   <= (r_t[2] > r_t[0]) ? r_t[2] : r_t[0];
            r_mf   <= (r_t[3] < r_t[1]) ? r_t[3] : r_t[1];
            r_zn   <= r_t[4];
            r_zf   <= r_t[5];
        end
    end

    // stage E: merge z, output register
    logic r_ov;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_vdd;
        end
    end

    always_ff @(posedge i_clk) begin
        logic ok;
        if (en) begin
            ok = r_ok_d && !((r_mn > r_zf) || (r_zn > r_mf));
            o_res.hit <= ok;
            if (!ok) begin
                o_res.entry_distance <= rbs_pkg::POS_MAX;
            end else begin
                o_res.entry_distance <= (r_zn > r_mn) ? r_zn : r_mn;
            end
        end
    end

endmodule

// ----- hw/rtl/rbs_check.sv -----
module rbs_check (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input rbs_pkg::t_ray_out o_res
);

    a_stall_def: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall not tied to blocked output");

    a_miss_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.hit) |-> (o_res.entry_distance == rbs_pkg::POS_MAX))
        else $error("miss without maximum distance");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_res)))
        else $error("stalled result changed");

    a_free_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("stall raised with empty output");

endmodule

bind ray_box_slab_intersect rbs_check u_rbs_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);
